// ===== hw/rtl/u8d_pkg.sv =====
// Shared types and constants for the UTF-8 decoder.
// Holds the job record passed from the front part through the queue to the back part.
// No dependencies.
package u8d_pkg;

   localparam int CP_W    = 21;
   localparam int BYTE_W  = 8;
   localparam int MAX_RES = 3;      // results one byte can cause
   localparam int HOLD_N  = 2;      // held continuation bytes
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic [7:0] ASCII_LIM  = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_CODE = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_CODE = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_CODE = 8'hF0;
   localparam logic [7:0] PAY2_MASK  = 8'h1F;
   localparam logic [7:0] PAY3_MASK  = 8'h0F;
   localparam logic [7:0] PAY4_MASK  = 8'h07;
   localparam logic [7:0] CONT_MASK  = 8'h3F;

   // one accepted byte's worth of results
   typedef struct packed {
      logic [1:0]                        cnt;   // results in this job, 1..3
      logic                              bare;  // end marker without character
      logic                              fin;   // job closes the string
      logic [MAX_RES-1:0][CP_W-1:0]      cp;
   } job_type;

   function automatic logic is_lead2(input logic [7:0] b);
      return (b & LEAD2_MASK) == LEAD2_CODE;
   endfunction

   function automatic logic is_lead3(input logic [7:0] b);
      return (b & LEAD3_MASK) == LEAD3_CODE;
   endfunction

   function automatic logic is_lead4(input logic [7:0] b);
      return (b & LEAD4_MASK) == LEAD4_CODE;
   endfunction

endpackage

// ===== hw/rtl/u8d_front.sv =====
// Front part of the UTF-8 decoder: takes bytes, tracks open sequences, builds
// one job per byte that yields results or ends the string. Depends on u8d_pkg.
module u8d_front import u8d_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [7:0]        req_in_byte,
   input  logic              req_final_byte,
   input  logic              q_full,
   output logic              push,
   output job_type           push_job
);

   logic [1:0]              pend_ff, pend_in;
   logic [CP_W-1:0]         part_ff, part_in;
   logic [1:0]              hcnt_ff, hcnt_in;
   logic [HOLD_N-1:0][7:0]  held_ff, held_in;

   logic                    acc;
   logic [1:0]              n;
   logic [MAX_RES-1:0][CP_W-1:0] cps;
   logic [MAX_RES-1:0][7:0] seq;
   logic [1:0]              hc;
   logic [2:0]              len;
   logic [2:0]              pos;
   logic [7:0]              c;
   logic [7:0]              b;
   logic                    fin;

   assign acc = req_valid && !q_full;
   assign b   = req_in_byte;
   assign fin = req_final_byte;

   always_comb begin
      pend_in = pend_ff;
      part_in = part_ff;
      hcnt_in = hcnt_ff;
      held_in = held_ff;
      n       = '0;
      cps     = '0;
      pos     = '0;
      c       = '0;
      hc      = (hcnt_ff > 2'(HOLD_N)) ? 2'(HOLD_N) : hcnt_ff;
      len     = 3'(hc) + 3'd1;
      for (int j = 0; j < MAX_RES; j++) begin
         if (2'(j) < hc) begin
            seq[j] = held_ff[j];
         end else if (2'(j) == hc) begin
            seq[j] = b;
         end else begin
            seq[j] = '0;
         end
      end

      if (acc) begin
         if (pend_ff == 2'd0) begin
            if (b < ASCII_LIM) begin
               cps[0] = CP_W'(b);
               n      = 2'd1;
            end else if (!fin) begin
               if (is_lead2(b)) begin
                  pend_in = 2'd1;
                  part_in = CP_W'(b & PAY2_MASK);
               end else if (is_lead3(b)) begin
                  pend_in = 2'd2;
                  part_in = CP_W'(b & PAY3_MASK);
               end else if (is_lead4(b)) begin
                  pend_in = 2'd3;
                  part_in = CP_W'(b & PAY4_MASK);
               end
            end
         end else if (pend_ff == 2'd1) begin
            cps[0]  = {part_ff[CP_W-7:0], b[5:0]};
            n       = 2'd1;
            pend_in = '0;
            part_in = '0;
            hcnt_in = '0;
         end else if (!fin) begin
            part_in = {part_ff[CP_W-7:0], b[5:0]};
            pend_in = pend_ff - 2'd1;
            if (hcnt_ff < 2'(HOLD_N)) begin
               held_in[hcnt_ff[0]] = b;
               hcnt_in = hcnt_ff + 2'd1;
            end
         end else begin
            // string ends mid-sequence: drop lead, rescan held bytes and this one
            for (int s = 0; s < MAX_RES; s++) begin
               if (pos < len) begin
                  c = seq[pos[1:0]];
                  if (c < ASCII_LIM) begin
                     cps[n] = CP_W'(c);
                     n      = n + 2'd1;
                     pos    = pos + 3'd1;
                  end else if (is_lead2(c) && (pos + 3'd1 < len)) begin
                     cps[n] = CP_W'({c[4:0], seq[pos[1:0] + 2'd1][5:0]});
                     n      = n + 2'd1;
                     pos    = pos + 3'd2;
                  end else begin
                     pos    = pos + 3'd1;
                  end
               end
            end
         end
         if (fin) begin
            pend_in = '0;
            part_in = '0;
            hcnt_in = '0;
         end
      end
   end

   assign push          = acc && ((n != 2'd0) || fin);
   assign push_job.cnt  = (n == 2'd0) ? 2'd1 : n;
   assign push_job.bare = (n == 2'd0);
   assign push_job.fin  = fin;
   assign push_job.cp   = cps;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         part_ff <= '0;
         hcnt_ff <= '0;
      end else begin
         pend_ff <= pend_in;
         part_ff <= part_in;
         hcnt_ff <= hcnt_in;
      end
   end

   // held bytes are read only below the held count
   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

endmodule

// ===== hw/rtl/u8d_queue.sv =====
// Short job queue between the front and back parts of the UTF-8 decoder.
// Depends on u8d_pkg.
module u8d_queue import u8d_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  job_type  push_job,
   input  logic     pop,
   output logic     full,
   output logic     head_valid,
   output job_type  head_job
);

   job_type [Q_DEPTH-1:0] mem_ff;
   logic [Q_PTR_W-1:0]    wr_ff, wr_in;
   logic [Q_PTR_W-1:0]    rd_ff, rd_in;
   logic [Q_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                  do_wr;
   logic                  do_rd;

   assign full       = (cnt_ff == Q_CNT_W'(Q_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_job   = mem_ff[rd_ff];
   assign do_wr      = push && !full;
   assign do_rd      = pop && head_valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_wr) begin
         wr_in = (wr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ff + Q_PTR_W'(1);
      end
      if (do_rd) begin
         rd_in = (rd_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ff + Q_PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + Q_CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

endmodule

// ===== hw/rtl/u8d_back.sv =====
// Back part of the UTF-8 decoder: walks the results of the head job and
// drives the registered result channel. Depends on u8d_pkg.
module u8d_back import u8d_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  job_type          head_job,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [CP_W-1:0]  rsp_code_point,
   output logic             rsp_has_char,
   output logic             rsp_string_end,
   output logic             rsp_run_last
);

   logic [1:0]       idx_ff, idx_in;
   logic             vld_ff, vld_in;
   logic [CP_W-1:0]  cp_ff;
   logic             has_ff;
   logic             end_ff;
   logic             last_ff;
   logic             load;
   logic             last;
   logic [CP_W-1:0]  cp_sel;

   assign load = head_valid && (!vld_ff || !rsp_stall);
   assign last = (idx_ff == head_job.cnt - 2'd1);
   assign pop  = load && last;

   always_comb begin
      case (idx_ff)
         2'd0:    cp_sel = head_job.cp[0];
         2'd1:    cp_sel = head_job.cp[1];
         2'd2:    cp_sel = head_job.cp[2];
         default: cp_sel = '0;
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      vld_in = vld_ff && rsp_stall;
      if (load) begin
         vld_in = 1'b1;
         idx_in = last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cp_ff   <= cp_sel;
         has_ff  <= !head_job.bare;
         end_ff  <= last && head_job.fin;
         last_ff <= last;
      end
   end

   assign rsp_valid      = vld_ff;
   assign rsp_code_point = cp_ff;
   assign rsp_has_char   = has_ff;
   assign rsp_string_end = end_ff;
   assign rsp_run_last   = last_ff;

endmodule

// ===== hw/rtl/utf8_to_code_point_decoder_top.sv =====
// Top level of the UTF-8 to code point decoder.
// Instantiates u8d_front, u8d_queue and u8d_back; depends on u8d_pkg.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------------
//   req     | in        | req_valid/req_stall | req_in_byte, req_final_byte
//   rsp     | out       | rsp_valid/rsp_stall | rsp_code_point, rsp_has_char,
//           |           |                     | rsp_string_end, rsp_run_last
//
// One byte is taken per cycle while req_stall is low. A byte yielding one result
// shows it on rsp after the queue write and then the output register; a byte
// yielding two or three results is drained by the single output register, one
// result per cycle while rsp_stall is low.
// Reset (synchronous, active high) clears the sequence state, the queue and the
// output valid. req_stall is high only while the two-entry job queue is full;
// rsp_stall holds the output register and, once the queue fills, backs up req.
module utf8_to_code_point_decoder_top import u8d_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_in_byte,
   input  logic             req_final_byte,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [CP_W-1:0]  rsp_code_point,
   output logic             rsp_has_char,
   output logic             rsp_string_end,
   output logic             rsp_run_last
);

   logic    q_full;
   logic    push;
   job_type push_job;
   logic    pop;
   logic    head_valid;
   job_type head_job;

   // stall the byte stream only when no room for another job
   assign req_stall = q_full;

   // front: classify bytes, keep the open sequence, build result jobs
   u8d_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_in_byte    (req_in_byte),
      .req_final_byte (req_final_byte),
      .q_full         (q_full),
      .push           (push),
      .push_job       (push_job)
   );

   // decouples front from back so each side stalls independently
   u8d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // back: one result transaction per cycle from the head job while rsp_stall is low
   u8d_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_job       (head_job),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_code_point (rsp_code_point),
      .rsp_has_char   (rsp_has_char),
      .rsp_string_end (rsp_string_end),
      .rsp_run_last   (rsp_run_last)
   );

endmodule
